// ----- rtl/core/utf8_to_utf16_transcoder_defines.svh -----
// Assertion macros shared by the transcoder RTL.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UTT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("utt assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define UTT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("utt assertion failed");

`endif

// ----- rtl/core/utt_pkg.sv -----
package utt_pkg;

   // Byte classification masks and patterns
   localparam logic [7:0] AsciiLimit   = 8'h80;
   localparam logic [7:0] Lead2Mask    = 8'hE0;
   localparam logic [7:0] Lead2Code    = 8'hC0;
   localparam logic [7:0] Lead3Mask    = 8'hF0;
   localparam logic [7:0] Lead3Code    = 8'hE0;
   localparam logic [7:0] Lead4Mask    = 8'hF8;
   localparam logic [7:0] Lead4Code    = 8'hF0;
   localparam logic [7:0] ContMask     = 8'hC0;
   localparam logic [7:0] ContCode     = 8'h80;

   // Code point limits
   localparam logic [20:0] SurrogateLow  = 21'h00D800;
   localparam logic [20:0] SurrogateHigh = 21'h00DFFF;
   localparam logic [20:0] BmpMax        = 21'h00FFFF;
   localparam logic [20:0] CodeMax       = 21'h10FFFF;
   localparam logic [20:0] SuppBase      = 21'h010000;
   localparam logic [15:0] HighSurrBase  = 16'hD800;
   localparam logic [15:0] LowSurrBase   = 16'hDC00;

   // Output queue depth
   localparam int unsigned QueueDepth = 2;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        unit_valid;
      logic        string_end;
      logic        string_error;
      logic        run_last;
   } utt_result_type;

endpackage

// ----- rtl/core/utf8_to_utf16_transcoder.sv -----
// UTF-8 to UTF-16 transcoder. Takes one byte per cycle on req_ and returns
// UTF-16 units on rsp_, one result per cycle: a supplementary character
// yields a high/low surrogate pair on two consecutive results, and the last
// byte of a string always yields a result that carries string_end (with
// string_error set on an end-only result when the string was rejected).
// A byte is held in the input register, is decoded there and lands in a
// two-entry result queue whose head is presented on rsp_. Sustained rate
// is one byte per cycle while rsp_ready stays high; input stalls only when
// the result queue lacks room for the results of the byte in the input
// register.
`include "utf8_to_utf16_transcoder_defines.svh"

module utf8_to_utf16_transcoder
   import utt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_string_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_unit_valid,
   output logic        rsp_string_end,
   output logic        rsp_string_error,
   output logic        rsp_run_last
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic [1:0]     result_count;
   utt_result_type result0;
   utt_result_type result1;
   utt_result_type q_ff [QueueDepth];
   utt_result_type q_in [QueueDepth];
   logic [1:0]     cnt_ff;
   logic [1:0]     cnt_in;
   logic           pop;
   logic           fire;
   logic [2:0]     fill_after;

   utt_decoder u_decoder (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .in_byte      (in_byte_ff),
      .string_last  (in_last_ff),
      .result_count (result_count),
      .result0      (result0),
      .result1      (result1)
   );

   // Decode when the queue has room for this byte's results
   assign pop        = rsp_valid && rsp_ready;
   assign fill_after = {1'b0, cnt_ff} - {2'b00, pop} + {1'b0, result_count};
   assign fire       = in_valid_ff && (fill_after <= 3'(QueueDepth));
   assign req_ready  = !in_valid_ff || fire;

   // Hold the accepted transaction in the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_string_last;
      end
   end

   // Drop the delivered head, then append new results
   always_comb begin
      logic [1:0] cnt_tmp;

      q_in    = q_ff;
      cnt_tmp = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_tmp = cnt_ff - 2'd1;
      end
      if (fire) begin
         if (result_count == 2'd2) begin
            q_in[0] = result0;
            q_in[1] = result1;
         end else if (result_count == 2'd1) begin
            q_in[cnt_tmp[0]] = result0;
         end
         cnt_in = cnt_tmp + result_count;
      end else begin
         cnt_in = cnt_tmp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   // Present the queue head
   assign rsp_valid        = (cnt_ff != 2'd0);
   assign rsp_code_unit    = q_ff[0].code_unit;
   assign rsp_unit_valid   = q_ff[0].unit_valid;
   assign rsp_string_end   = q_ff[0].string_end;
   assign rsp_string_error = q_ff[0].string_error;
   assign rsp_run_last     = q_ff[0].run_last;

   `UTT_ASSERT_NOW(a_cnt_range, 1'b1, cnt_ff <= 2'(QueueDepth))
   `UTT_ASSERT_NOW(a_pair_together, rsp_valid && !rsp_run_last, cnt_ff == 2'(QueueDepth))
   `UTT_ASSERT_NOW(a_error_on_end_only, rsp_valid && rsp_string_error,
                   rsp_string_end && !rsp_unit_valid)

endmodule

// ----- rtl/core/utt_decoder.sv -----
`include "utf8_to_utf16_transcoder_defines.svh"

module utt_decoder
   import utt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  logic [7:0]     in_byte,
   input  logic           string_last,
   output logic [1:0]     result_count,
   output utt_result_type result0,
   output utt_result_type result1
);

   logic [20:0] partial_ff;
   logic [20:0] partial_in;
   logic [1:0]  remain_ff;
   logic [1:0]  remain_in;
   logic        error_ff;
   logic        error_in;

   // Decode one byte against the current character state
   always_comb begin
      logic [20:0] cp;
      logic [20:0] cp_off;
      logic [15:0] unit0;
      logic [15:0] unit1;
      logic [1:0]  n;
      logic        err_n;

      cp       = {partial_ff[14:0], in_byte[5:0]};
      cp_off   = cp - SuppBase;
      unit0    = 16'h0000;
      unit1    = 16'h0000;
      n        = 2'd0;
      err_n    = error_ff;
      partial_in = partial_ff;
      remain_in  = remain_ff;

      if (!error_ff) begin
         if (remain_ff == 2'd0) begin
            if (in_byte < AsciiLimit) begin
               unit0 = {8'h00, in_byte};
               n     = 2'd1;
            end else if ((in_byte & Lead2Mask) == Lead2Code) begin
               partial_in = {16'h0000, in_byte[4:0]};
               remain_in  = 2'd1;
            end else if ((in_byte & Lead3Mask) == Lead3Code) begin
               partial_in = {17'h00000, in_byte[3:0]};
               remain_in  = 2'd2;
            end else if ((in_byte & Lead4Mask) == Lead4Code) begin
               partial_in = {18'h00000, in_byte[2:0]};
               remain_in  = 2'd3;
            end else begin
               err_n = 1'b1;
            end
         end else if ((in_byte & ContMask) != ContCode) begin
            // drop the partial character
            err_n      = 1'b1;
            remain_in  = 2'd0;
            partial_in = '0;
         end else begin
            partial_in = cp;
            remain_in  = remain_ff - 2'd1;
            if (remain_ff == 2'd1) begin
               partial_in = '0;
               if ((cp >= SurrogateLow && cp <= SurrogateHigh) || cp > CodeMax) begin
                  err_n = 1'b1;
               end else if (cp <= BmpMax) begin
                  unit0 = cp[15:0];
                  n     = 2'd1;
               end else begin
                  unit0 = HighSurrBase | {6'b000000, cp_off[19:10]};
                  unit1 = LowSurrBase | {6'b000000, cp_off[9:0]};
                  n     = 2'd2;
               end
            end
         end
      end

      // Build the results for this byte
      result0 = '{code_unit: unit0, unit_valid: 1'b1, string_end: 1'b0,
                  string_error: 1'b0, run_last: (n == 2'd1)};
      result1 = '{code_unit: unit1, unit_valid: 1'b1, string_end: 1'b0,
                  string_error: 1'b0, run_last: 1'b1};
      result_count = n;

      if (string_last) begin
         if (remain_in != 2'd0) begin
            err_n = 1'b1;
         end
         if (n == 2'd2) begin
            result1.string_end = 1'b1;
         end else if (n == 2'd1) begin
            result0.string_end = 1'b1;
         end else begin
            result0      = '{code_unit: 16'h0000, unit_valid: 1'b0, string_end: 1'b1,
                             string_error: err_n, run_last: 1'b1};
            result_count = 2'd1;
         end
         // return to the idle state at end of string
         err_n      = 1'b0;
         remain_in  = 2'd0;
         partial_in = '0;
      end

      error_in = err_n;
   end

   // Advance the character state on each decoded byte
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         remain_ff  <= 2'd0;
         error_ff   <= 1'b0;
      end else if (fire) begin
         partial_ff <= partial_in;
         remain_ff  <= remain_in;
         error_ff   <= error_in;
      end
   end

   `UTT_ASSERT_NEXT(a_end_clears_state, fire && string_last,
                    remain_ff == 2'd0 && !error_ff && partial_ff == '0)
   `UTT_ASSERT_NOW(a_idle_partial_zero, error_ff || remain_ff == 2'd0, partial_ff == '0)
   `UTT_ASSERT_NOW(a_last_has_result, string_last, result_count != 2'd0)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import utt_pkg::*;

   localparam int LongStall     = 300;
   localparam int ReportLimit   = 10;
   localparam int DrainCycles   = 10;
   localparam int NormalIdlePct = 33;

   // Ways a random string can be broken
   typedef enum int {
      FLAW_NONE,
      FLAW_SURROGATE,
      FLAW_TOO_LARGE,
      FLAW_BAD_LEAD,
      FLAW_BAD_CONT,
      FLAW_TRUNCATED,
      FLAW_OVERLONG,
      FLAW_NOISE
   } flaw_type;

   typedef struct packed {
      logic [7:0] data;
      logic       string_last;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_string_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_code_unit;
   logic        rsp_unit_valid;
   logic        rsp_string_end;
   logic        rsp_string_error;
   logic        rsp_run_last;

   // Stimulus and scoreboard storage
   byte_item_type  pending_bytes[$];
   logic [7:0]     string_bytes[$];
   utt_result_type expected_units[$];
   int             bytes_queued = 0;
   int             mismatch_count = 0;
   logic           req_fire = 1'b0;

   // Idle control
   int send_idle_pct = NormalIdlePct;
   int recv_idle_pct = NormalIdlePct;
   int stall_request = 0;
   int stall_granted = 0;
   int stall_left = 0;

   // Decoder state mirrored by the scoreboard
   logic [20:0] partial_cp = '0;
   logic [1:0]  cont_left = '0;
   logic        string_bad = 1'b0;

   utf8_to_utf16_transcoder dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Append one expected result transaction
   function automatic void add_expected(input utt_result_type r);
      expected_units.insert(expected_units.size(), r);
   endfunction

   // Append one byte to the string under construction
   function automatic void add_byte(input logic [7:0] b);
      string_bytes.insert(string_bytes.size(), b);
   endfunction

   // Decode one accepted byte and queue the UTF-16 results it produces
   function automatic void decode_byte(input logic [7:0] b, input logic lst);
      logic [15:0]    units [2];
      logic [20:0]    cp;
      int             n;
      utt_result_type r;
      n = 0;
      cp = '0;
      units[0] = '0;
      units[1] = '0;
      if (!string_bad) begin
         if (cont_left == 2'd0) begin
            if (b < AsciiLimit) begin
               units[0] = {8'h00, b};
               n = 1;
            end else if ((b & Lead2Mask) == Lead2Code) begin
               partial_cp = {16'd0, b[4:0]};
               cont_left = 2'd1;
            end else if ((b & Lead3Mask) == Lead3Code) begin
               partial_cp = {17'd0, b[3:0]};
               cont_left = 2'd2;
            end else if ((b & Lead4Mask) == Lead4Code) begin
               partial_cp = {18'd0, b[2:0]};
               cont_left = 2'd3;
            end else begin
               string_bad = 1'b1;
            end
         end else if ((b & ContMask) != ContCode) begin
            string_bad = 1'b1;
            cont_left = 2'd0;
            partial_cp = '0;
         end else begin
            partial_cp = {partial_cp[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
               cp = partial_cp;
               partial_cp = '0;
               if ((cp >= SurrogateLow && cp <= SurrogateHigh) || cp > CodeMax) begin
                  string_bad = 1'b1;
               end else if (cp <= BmpMax) begin
                  units[0] = cp[15:0];
                  n = 1;
               end else begin
                  cp = cp - SuppBase;
                  units[0] = HighSurrBase + {6'd0, cp[19:10]};
                  units[1] = LowSurrBase + {6'd0, cp[9:0]};
                  n = 2;
               end
            end
         end
      end

      // Mid-string bytes only carry the units they complete
      if (!lst) begin
         for (int k = 0; k < n; k++) begin
            r.code_unit = units[k];
            r.unit_valid = 1'b1;
            r.string_end = 1'b0;
            r.string_error = 1'b0;
            r.run_last = (k == n - 1);
            add_expected(r);
         end
      end else begin
         if (cont_left != 2'd0) string_bad = 1'b1;
         if (n > 0) begin
            for (int k = 0; k < n; k++) begin
               r.code_unit = units[k];
               r.unit_valid = 1'b1;
               r.string_end = (k == n - 1);
               r.string_error = 1'b0;
               r.run_last = (k == n - 1);
               add_expected(r);
            end
         end else begin
            r.code_unit = '0;
            r.unit_valid = 1'b0;
            r.string_end = 1'b1;
            r.string_error = string_bad;
            r.run_last = 1'b1;
            add_expected(r);
         end
         partial_cp = '0;
         cont_left = 2'd0;
         string_bad = 1'b0;
      end
   endfunction

   task automatic log_mismatch(input string why, input utt_result_type want,
                               input utt_result_type seen);
      if (mismatch_count < ReportLimit)
         $display("%0t: %s: expected %h/%b%b%b%b, got %h/%b%b%b%b (unit/valid end err last)",
                  $time, why, want.code_unit, want.unit_valid, want.string_end,
                  want.string_error, want.run_last, seen.code_unit, seen.unit_valid,
                  seen.string_end, seen.string_error, seen.run_last);
      mismatch_count++;
   endtask

   // Encode a code point into string_bytes; nbytes of 0 picks the natural length
   function automatic int append_char(input logic [20:0] cp, input int nbytes);
      int len;
      len = nbytes;
      if (len == 0) begin
         if (cp < 21'h80) len = 1;
         else if (cp < 21'h800) len = 2;
         else if (cp < SuppBase) len = 3;
         else len = 4;
      end
      case (len)
         1: begin
            add_byte(cp[7:0]);
         end
         2: begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
         end
         3: begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
         default: begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
      endcase
      return len;
   endfunction

   // Random scalar value; min_class 1 forces a multibyte character
   function automatic logic [20:0] pick_code_point(input int min_class);
      logic [20:0] v;
      case ($urandom_range(3, min_class))
         0: v = 21'($urandom_range(21'h7F));
         1: v = 21'($urandom_range(21'h7FF, 21'h80));
         2: begin
            v = 21'($urandom_range(21'hF7FF, 21'h800));
            if (v >= SurrogateLow) v = v + 21'h800;
         end
         default: v = 21'($urandom_range(CodeMax, SuppBase));
      endcase
      return v;
   endfunction

   // Move the assembled string to the driver queue, marking its final byte
   task automatic flush_string();
      byte_item_type t;
      for (int i = 0; i < string_bytes.size(); i++) begin
         t.data = string_bytes[i];
         t.string_last = (i == string_bytes.size() - 1);
         pending_bytes.insert(pending_bytes.size(), t);
      end
      bytes_queued += string_bytes.size();
      string_bytes.delete();
   endtask

   task automatic queue_directed(input logic [31:0] word, input int count);
      for (int i = count - 1; i >= 0; i--) add_byte(word[i*8 +: 8]);
      flush_string();
   endtask

   // Build one random string, mostly well formed, sometimes broken
   task automatic build_string();
      flaw_type    flaw;
      int          nchars;
      int          at;
      int          len;
      int          cut;
      logic [7:0]  b;
      nchars = $urandom_range(6, 1);
      flaw = FLAW_NONE;
      if ($urandom_range(99) >= 70)
         flaw = flaw_type'($urandom_range(FLAW_NOISE, FLAW_SURROGATE));
      at = $urandom_range(nchars - 1);
      if (flaw == FLAW_TRUNCATED) at = nchars - 1;

      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255)));
      end else begin
         for (int i = 0; i < nchars; i++) begin
            if (i != at || flaw == FLAW_NONE) begin
               len = append_char(pick_code_point(0), 0);
            end else begin
               case (flaw)
                  FLAW_SURROGATE:
                     len = append_char(21'($urandom_range(SurrogateHigh, SurrogateLow)), 3);
                  FLAW_TOO_LARGE:
                     len = append_char(21'($urandom_range(21'h1FFFFF, CodeMax + 1)), 4);
                  FLAW_BAD_LEAD: begin
                     if ($urandom_range(1)) add_byte(8'($urandom_range(8'hBF, 8'h80)));
                     else add_byte(8'($urandom_range(8'hFF, 8'hF8)));
                  end
                  FLAW_OVERLONG:
                     len = append_char(21'($urandom_range(21'h7FF)), $urandom_range(4, 2));
                  default: begin
                     // Cut a multibyte character short
                     len = append_char(pick_code_point(1), 0);
                     cut = $urandom_range(len - 1, 1);
                     repeat (cut) void'(string_bytes.pop_back());
                     if (flaw == FLAW_BAD_CONT) begin
                        b = 8'($urandom_range(255));
                        if (b[7:6] == 2'b10) b[6] = 1'b1;
                        add_byte(b);
                     end
                  end
               endcase
            end
         end
      end
      flush_string();
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_units.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int target;
      target = bytes_queued + count;
      while (bytes_queued < target) build_string();
   endtask

   // Drive request transactions at the falling edge
   always @(negedge clock) begin : drive_bytes
      byte_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_in_byte <= nxt.data;
            req_string_last <= nxt.string_last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Drive rsp_ready, with long hold-offs on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_request != stall_granted) begin
         stall_granted <= stall_request;
         stall_left <= LongStall;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Record accepted bytes and check each response transaction
   always @(posedge clock) begin : check_results
      utt_result_type seen;
      utt_result_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) decode_byte(req_in_byte, req_string_last);
         if (rsp_valid && rsp_ready) begin
            seen.code_unit = rsp_code_unit;
            seen.unit_valid = rsp_unit_valid;
            seen.string_end = rsp_string_end;
            seen.string_error = rsp_string_error;
            seen.run_last = rsp_run_last;
            if (expected_units.size() == 0) begin
               want = '0;
               log_mismatch("unexpected result", want, seen);
            end else begin
               want = expected_units.pop_front();
               if (seen !== want) log_mismatch("result mismatch", want, seen);
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Directed strings: plain, each lead length, extremes and each error kind
      queue_directed(32'h0000_007F, 2);
      queue_directed(32'h0000_0041, 1);
      queue_directed(32'h0000_C2A9, 2);
      queue_directed(32'h00E2_82AC, 3);
      queue_directed(32'hF09F_9880, 4);
      queue_directed(32'hF48F_BFBF, 4);
      queue_directed(32'h00ED_A080, 3);
      queue_directed(32'hF490_8080, 4);
      queue_directed(32'h0000_00FF, 1);
      queue_directed(32'h00C2_4142, 3);
      queue_directed(32'h0000_E282, 2);
      wait_drained();

      run_random(450);
      wait_drained();

      // Hold the receiver off while the sender keeps offering bytes
      send_idle_pct = 0;
      stall_request = stall_request + 1;
      run_random(250);
      wait_drained();

      // Back-to-back traffic with no idle cycles on either side
      recv_idle_pct = 0;
      run_random(300);
      wait_drained();

      send_idle_pct = NormalIdlePct;
      recv_idle_pct = NormalIdlePct;
      run_random(450);
      wait_drained();

      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_units.size() == 0)
         $display("utf8_to_utf16_transcoder verification clean");
      else
         $display("utf8_to_utf16_transcoder verification failed");
      $finish;
   end

   // Abort a hung run
   initial begin
      #4000000;
      $display("utf8_to_utf16_transcoder verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/utt_pkg.sv
rtl/core/utt_decoder.sv
rtl/core/utf8_to_utf16_transcoder.sv
tb/tb.sv
